// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, muted while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check without a reset qualifier.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/olist_pkg.sv =====
package olist_pkg;

  // List capacity and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;
  localparam int FOUND_W  = 6;

  // Stream payload layout
  localparam int IN_BITS   = OP_W + POS_W + VAL_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = ST_W + VAL_W + FOUND_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT       = 3'd0,
    OP_APPEND       = 3'd1,
    OP_REMOVE_AT    = 3'd2,
    OP_REMOVE_VALUE = 3'd3,
    OP_FIND         = 3'd4,
    OP_GET          = 3'd5,
    OP_CLEAR        = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_UPDATE
  } state_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic             scan;
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

  // Lowest set bit of a match vector
  function automatic logic [IDX_W-1:0] first_set(input logic [CAPACITY-1:0] v);
    logic [IDX_W-1:0] f;
    f = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (v[i]) f = IDX_W'(i);
    end
    return f;
  endfunction

endpackage

// ===== rtl/olist_cell.sv =====
module olist_cell (
  input  logic                           clk,
  input  logic [olist_pkg::IDX_W-1:0]    idx,
  input  olist_pkg::cell_ctl_t           ctl,
  input  logic [olist_pkg::VAL_W-1:0]    lower_val,
  input  logic [olist_pkg::VAL_W-1:0]    upper_val,
  output logic [olist_pkg::VAL_W-1:0]    entry,
  output logic                           match,
  output logic                           sel
);
  import olist_pkg::*;

  logic [VAL_W-1:0] entry_r, entry_nxt;
  logic             match_r, sel_r;
  logic [CNT_W-1:0] my_pos;

  assign my_pos = CNT_W'(idx);

  // Shift up on insert, down on remove; write the new value at its slot
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (my_pos == ctl.pos) entry_nxt = ctl.value;
      else if (my_pos > ctl.pos) entry_nxt = lower_val;
    end else if (ctl.rem) begin
      if (my_pos >= ctl.pos) entry_nxt = upper_val;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    // compare flags captured during the scan step
    if (ctl.scan) begin
      match_r <= (entry_r == ctl.value) && (my_pos < ctl.count);
      sel_r   <= (my_pos == ctl.pos);
    end
  end

  assign entry = entry_r;
  assign match = match_r;
  assign sel   = sel_r;

endmodule

// ===== rtl/ordered_int_list_engine.sv =====
// Ordered list of up to 64 signed 32-bit entries held in a row of cells, one entry per
// cell. Each input transfer carries one operation (insert, append, remove at position,
// remove value, find, get, clear) and gives exactly one result transfer with status,
// read value, found position and the entry count after the operation. An item passes
// through an accept step, a scan step in which every cell compares its entry at once, a
// resolve step that picks the lowest matching cell and the addressed entry, and an update
// step in which the cells from the addressed position upward shift one place together.
// The next item is accepted the cycle after the update, so a new item is not taken until
// the previous one has finished its update. The result sits in an output register; the update
// step of the following item waits while that result has not been taken.
module ordered_int_list_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // op[2:0], position[9:3], item_value[41:10], zero fill above
  input  logic [olist_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[1:0], read_value[33:2], found_position[39:34], entry_count[46:40], zero fill
  output logic [olist_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import olist_pkg::*;

  state_t state_r, state_nxt;

  // Captured operation
  logic [OP_W-1:0]  op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [CNT_W-1:0] count_r;

  // Resolved outcome
  logic [ST_W-1:0]    res_status_r, res_status_nxt;
  logic [VAL_W-1:0]   res_rd_r, res_rd_nxt;
  logic [FOUND_W-1:0] res_found_r, res_found_nxt;
  logic               res_ins_r, res_ins_nxt;
  logic               res_rem_r, res_rem_nxt;
  logic [POS_W-1:0]   res_pos_r, res_pos_nxt;
  logic [CNT_W-1:0]   res_count_r, res_count_nxt;

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Cell row wiring
  cell_ctl_t         ctl;
  logic [VAL_W-1:0]  entry_w [CAPACITY];
  logic [CAPACITY-1:0] match_w, sel_w;
  logic              in_xfer, out_free, do_update;
  logic              any_match;
  logic [IDX_W-1:0]  first_idx;
  logic [VAL_W-1:0]  sel_data;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] lower_w, upper_w;
    if (g == 0) begin : g_lo_end
      assign lower_w = val_r;
    end else begin : g_lo
      assign lower_w = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi_end
      assign upper_w = entry_w[g];
    end else begin : g_hi
      assign upper_w = entry_w[g+1];
    end
    olist_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(g)),
      .ctl       (ctl),
      .lower_val (lower_w),
      .upper_val (upper_w),
      .entry     (entry_w[g]),
      .match     (match_w[g]),
      .sel       (sel_w[g])
    );
  end

  // Gather: lowest match and the addressed entry
  always_comb begin
    sel_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_data = sel_data | (sel_w[i] ? entry_w[i] : '0);
    end
  end
  assign any_match = |match_w;
  assign first_idx = first_set(match_w);

  // Decide status, shift command and new count
  always_comb begin
    res_status_nxt = ST_OK;
    res_rd_nxt     = '0;
    res_found_nxt  = '0;
    res_ins_nxt    = 1'b0;
    res_rem_nxt    = 1'b0;
    res_pos_nxt    = pos_r;
    res_count_nxt  = count_r;
    case (op_r)
      OP_INSERT: begin
        if (count_r >= CNT_W'(CAPACITY)) res_status_nxt = ST_FULL;
        else if (pos_r > count_r) res_status_nxt = ST_RANGE;
        else begin
          res_ins_nxt   = 1'b1;
          res_count_nxt = count_r + 1'b1;
        end
      end
      OP_APPEND: begin
        if (count_r >= CNT_W'(CAPACITY)) res_status_nxt = ST_FULL;
        else begin
          res_ins_nxt   = 1'b1;
          res_pos_nxt   = count_r;
          res_count_nxt = count_r + 1'b1;
        end
      end
      OP_REMOVE_AT: begin
        if (pos_r >= count_r) res_status_nxt = ST_RANGE;
        else begin
          res_rem_nxt   = 1'b1;
          res_rd_nxt    = sel_data;
          res_count_nxt = count_r - 1'b1;
        end
      end
      OP_REMOVE_VALUE: begin
        if (!any_match) res_status_nxt = ST_ABSENT;
        else begin
          res_rem_nxt   = 1'b1;
          res_pos_nxt   = POS_W'(first_idx);
          res_found_nxt = FOUND_W'(first_idx);
          res_count_nxt = count_r - 1'b1;
        end
      end
      OP_FIND: begin
        if (!any_match) res_status_nxt = ST_ABSENT;
        else res_found_nxt = FOUND_W'(first_idx);
      end
      OP_GET: begin
        if (pos_r >= count_r) res_status_nxt = ST_RANGE;
        else res_rd_nxt = sel_data;
      end
      OP_CLEAR: begin
        res_count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_xfer) state_nxt = S_SCAN;
      S_SCAN:    state_nxt = S_RESOLVE;
      S_RESOLVE: state_nxt = S_UPDATE;
      S_UPDATE:  if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready  = 1'b0;
    do_update  = 1'b0;
    ctl        = '0;
    ctl.count  = count_r;
    ctl.value  = val_r;
    ctl.pos    = pos_r;
    case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_SCAN: ctl.scan = 1'b1;
      S_RESOLVE: begin
      end
      S_UPDATE: begin
        do_update = out_free;
        ctl.pos   = res_pos_r;
        ctl.ins   = out_free && res_ins_r;
        ctl.rem   = out_free && res_rem_r;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_update) begin
        count_r     <= res_count_r;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_tdata[OP_W-1:0];
      pos_r <= in_tdata[OP_W +: POS_W];
      val_r <= in_tdata[OP_W + POS_W +: VAL_W];
    end
    if (state_r == S_RESOLVE) begin
      res_status_r <= res_status_nxt;
      res_rd_r     <= res_rd_nxt;
      res_found_r  <= res_found_nxt;
      res_ins_r    <= res_ins_nxt;
      res_rem_r    <= res_rem_nxt;
      res_pos_r    <= res_pos_nxt;
      res_count_r  <= res_count_nxt;
    end
    if (do_update) begin
      out_data_r <= OUT_DATA_W'({res_count_r, res_found_r, res_rd_r, res_status_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/olist_chk.sv =====
`include "assert_macros.svh"

module olist_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [olist_pkg::IN_DATA_W-1:0]    in_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [olist_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import olist_pkg::*;

  logic [CNT_W-1:0]   chk_count;
  logic [FOUND_W-1:0] chk_found;
  logic [VAL_W-1:0]   chk_rd;
  logic [ST_W-1:0]    chk_status;
  logic               chk_in_seen;

  assign chk_status  = out_tdata[ST_W-1:0];
  assign chk_rd      = out_tdata[ST_W +: VAL_W];
  assign chk_found   = out_tdata[ST_W + VAL_W +: FOUND_W];
  assign chk_count   = out_tdata[ST_W + VAL_W + FOUND_W +: CNT_W];
  assign chk_in_seen = in_tvalid && in_tready && (in_tdata != '0 || in_tdata == '0);

  // A waiting result stays offered
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  // Entry count never exceeds capacity
  `ASSERT_CLK(a_count_cap, clk, rst_n, out_tvalid |-> chk_count <= CNT_W'(CAPACITY), "entry count above capacity")

  // A failed operation reports no data and no position
  `ASSERT_CLK(a_fail_zero, clk, rst_n, out_tvalid && chk_status != ST_OK |-> chk_rd == '0 && chk_found == '0, "failed operation carries data")

  // An item accepted now cannot have its result appear on the next edge
  `ASSERT_CLK(a_latency, clk, rst_n, chk_in_seen && !out_tvalid |=> !out_tvalid, "result appeared too early")

endmodule

bind ordered_int_list_engine olist_chk u_olist_chk (.*);
